// File: hw/rtl/ufr_pkg.sv
`default_nettype none

package ufr_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 9;
    localparam int CFG_W      = 5;
    localparam int NIBBLES    = DATA_W / 4;
    localparam int DEF_MAX_ROUNDS = 25;
    localparam logic [CFG_W-1:0] ROUND_COUNT_RST = CFG_W'(4);
    localparam logic [CNT_W-1:0] ACTIVE_MAX = '1;

    localparam logic [3:0] SBOX4 [16] = '{
        4'h2, 4'h9, 4'h7, 4'he, 4'h1, 4'hc, 4'ha, 4'h0,
        4'h4, 4'h3, 4'h8, 4'hd, 4'hf, 4'h6, 4'h5, 4'hb
    };

    localparam logic [4:0] PERM32 [32] = '{
        5'd20, 5'd16, 5'd28, 5'd24, 5'd17, 5'd21, 5'd25, 5'd29,
        5'd22, 5'd18, 5'd30, 5'd26, 5'd19, 5'd23, 5'd27, 5'd31,
        5'd11, 5'd15, 5'd3,  5'd7,  5'd14, 5'd10, 5'd6,  5'd2,
        5'd9,  5'd13, 5'd1,  5'd5,  5'd12, 5'd8,  5'd4,  5'd0
    };

    typedef struct packed {
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] left_out;
        logic [DATA_W-1:0] right_out;
        logic [CNT_W-1:0]  active_total;
    } t_out;

    // Block state handed from one round cell to the next.
    typedef struct packed {
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;
        logic [CNT_W-1:0]  count;
    } t_blk;

    function automatic logic [DATA_W-1:0] sub_nibbles(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] y;
        y = '0;
        for (int i = 0; i < NIBBLES; i++) begin
            y[4*i +: 4] = SBOX4[x[4*i +: 4]];
        end
        return y;
    endfunction

    function automatic logic [3:0] count_nonzero(input logic [DATA_W-1:0] y);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < NIBBLES; i++) begin
            n = n + 4'(y[4*i +: 4] != 4'h0);
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] bit_perm(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] y;
        y = '0;
        for (int i = 0; i < DATA_W; i++) begin
            y[PERM32[i]] = x[i];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/unkeyed_feistel_round_active_count_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         start / busy               i_in  (t_in: left_in, right_in)
// result    out        o_done strobe, one cycle   o_out (t_out: halves, active_total)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (round_count, 5 bits)
//
// One transaction is accepted every cycle; busy stays low.
// Results pass through the chain of round cells: every cell registers its block,
// and cells past the configured round count pass data on.
// Reset clears the valid bits of the chain and loads round_count with 4.
// The receiver cannot stall; each result shows on o_out for one cycle.
`default_nettype none

module unkeyed_feistel_round_active_count_top #(
    parameter int MAX_ROUNDS = ufr_pkg::DEF_MAX_ROUNDS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  ufr_pkg::t_in                    i_in,
    output logic                            o_done,
    output ufr_pkg::t_out                   o_out,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [ufr_pkg::CFG_W-1:0]  i_cfg_data
);
    import ufr_pkg::*;

    localparam int RW = $clog2(MAX_ROUNDS + 1);

    logic [CFG_W-1:0] r_round_count;
    logic [RW-1:0]    rounds_eff;
    t_blk             head_blk;

    // Chain taps: tap k feeds cell k, the last tap is the result.
    logic             tap_valid  [MAX_ROUNDS+1];
    logic [RW-1:0]    tap_rounds [MAX_ROUNDS+1];
    t_blk             tap_blk    [MAX_ROUNDS+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Hold the round count; take a new value on a config transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= ROUND_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_round_count <= i_cfg_data;
        end
    end

    // Clamp the round count to 1..MAX_ROUNDS; it travels with each block.
    always_comb begin
        if (32'(r_round_count) > MAX_ROUNDS) begin
            rounds_eff = RW'(MAX_ROUNDS);
        end else if (r_round_count == '0) begin
            rounds_eff = RW'(1);
        end else begin
            rounds_eff = RW'(r_round_count);
        end
        head_blk.left  = i_in.left_in;
        head_blk.right = i_in.right_in;
        head_blk.count = '0;
    end

    assign tap_valid[0]  = start && !busy;
    assign tap_rounds[0] = rounds_eff;
    assign tap_blk[0]    = head_blk;

    // Advance one round per active cell per cycle; cells past the round count pass the block on.
    for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_cell
        ufr_cell #(
            .MAX_ROUNDS (MAX_ROUNDS),
            .IDX        (k),
            .RW         (RW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (tap_valid[k]),
            .i_rounds (tap_rounds[k]),
            .i_blk    (tap_blk[k]),
            .o_valid  (tap_valid[k+1]),
            .o_rounds (tap_rounds[k+1]),
            .o_blk    (tap_blk[k+1])
        );
    end

    // The last cell's registers drive the result; a clamped round count is never
    // zero, so the rounds tap only qualifies the strobe.
    assign o_done             = tap_valid[MAX_ROUNDS] && (tap_rounds[MAX_ROUNDS] != '0);
    assign o_out.left_out     = tap_blk[MAX_ROUNDS].left;
    assign o_out.right_out    = tap_blk[MAX_ROUNDS].right;
    assign o_out.active_total = tap_blk[MAX_ROUNDS].count;

endmodule

`default_nettype wire

// File: hw/rtl/ufr_cell.sv
`default_nettype none

module ufr_cell #(
    parameter int MAX_ROUNDS = ufr_pkg::DEF_MAX_ROUNDS,
    parameter int IDX        = 0,
    parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rounds,
    input  ufr_pkg::t_blk      i_blk,
    output logic               o_valid,
    output logic [RW-1:0]      o_rounds,
    output ufr_pkg::t_blk      o_blk
);
    import ufr_pkg::*;

    logic [DATA_W-1:0] rot_a;
    logic [DATA_W-1:0] rot_b;
    logic [DATA_W-1:0] val_a;
    logic [DATA_W-1:0] val_b;
    logic [CNT_W:0]    sum;
    logic              active;
    t_blk              n_blk;
    logic              r_valid;
    logic [RW-1:0]     r_rounds;
    t_blk              r_blk;

    always_comb begin
        rot_a  = {i_blk.left[DATA_W-4:0], i_blk.left[DATA_W-1 -: 3]};
        rot_b  = {i_blk.left[7:0], i_blk.left[DATA_W-1:8]};
        val_a  = sub_nibbles(rot_a);
        val_b  = sub_nibbles(rot_b);
        sum    = {1'b0, i_blk.count} + (CNT_W+1)'(count_nonzero(val_a))
                 + (CNT_W+1)'(count_nonzero(val_b));
        active = 32'(i_rounds) > IDX;
        n_blk  = i_blk;
        if (active) begin
            n_blk.left  = bit_perm(val_a ^ i_blk.right ^ val_b);
            n_blk.right = bit_perm(i_blk.left);
            // saturate the count
            n_blk.count = sum[CNT_W] ? ACTIVE_MAX : sum[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rounds <= i_rounds;
        r_blk    <= n_blk;
    end

    assign o_valid  = r_valid;
    assign o_rounds = r_rounds;
    assign o_blk    = r_blk;

endmodule

`default_nettype wire
